@@ design/sfd_pkg.sv @@
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the serial frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

  localparam int MAX_DATA_DEF = 8;   // default payload capacity in bytes
  localparam int LEN_W        = 7;   // holds any length up to 127
  localparam logic [7:0] HEADER_BYTE = 8'h54;  // ASCII 'T'

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_HDR = 2'd1,
    STAT_BAD_LEN = 2'd2,
    STAT_BAD_SUM = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    F_WAIT = 3'd0,
    F_IDH  = 3'd1,
    F_IDL  = 3'd2,
    F_LEN  = 3'd3,
    F_DATA = 3'd4,
    F_CSUM = 3'd5
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_READ = 2'd1,
    B_EMIT = 2'd2
  } back_state_t;

  // Command from the parser to the output side.
  typedef struct packed {
    logic              is_frame;  // 1: emit buffered frame, 0: single status beat
    status_t           status;
    logic [15:0]       id;
    logic [LEN_W-1:0]  len;
  } cmd_t;

endpackage

`default_nettype wire

@@ design/sfd_ram.sv @@
// ----------------------------------------------------------------------------
// sfd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ design/sfd_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// sfd_cmd_queue
// Two-entry command queue between the parser and the output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_cmd_queue
  import sfd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head_cmd,
  output logic      full,
  output logic      empty
);

  cmd_t       entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign head_cmd = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

@@ design/sfd_front.sv @@
// ----------------------------------------------------------------------------
// sfd_front
// Byte parser: tracks the frame header, fills the payload buffer, checks the
// additive checksum if enabled and queues one command per finished or rejected frame.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_front
  import sfd_pkg::*;
#(
  parameter int MAX_DATA = MAX_DATA_DEF,
  parameter int AW       = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_wr_en,
  input  wire logic          cfg_wr_data,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [7:0]    in_byte,
  input  wire logic          q_full,
  output logic               q_push,
  output cmd_t               q_cmd,
  input  wire logic          buf_done,
  output logic               ram_wr_en,
  output logic [AW-1:0]      ram_wr_addr,
  output logic [7:0]         ram_wr_data
);

  localparam logic [7:0] MAX_B = 8'(MAX_DATA);

  front_state_t     state_r, state_nxt;
  logic             cks_en_r;
  logic             busy_r, busy_nxt;
  logic [15:0]      id_r, id_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic             accept;
  logic [LEN_W-1:0] cnt_inc;

  // Data bytes wait while the previous frame is still read out of the buffer.
  assign in_tready = !q_full && !(state_r == F_DATA && busy_r);
  assign accept    = in_tvalid && in_tready;
  assign cnt_inc   = cnt_r + LEN_W'(1);

  assign ram_wr_addr = cnt_r[AW-1:0];
  assign ram_wr_data = in_byte;

  always_comb begin
    state_nxt = state_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    q_push    = 1'b0;
    q_cmd     = '{is_frame: 1'b0, status: STAT_OK, id: id_r, len: len_r};
    ram_wr_en = 1'b0;
    if (accept) begin
      unique case (state_r)
        F_IDH: begin
          id_nxt    = {in_byte, 8'h00};
          sum_nxt   = in_byte;
          state_nxt = F_IDL;
        end
        F_IDL: begin
          id_nxt    = {id_r[15:8], in_byte};
          sum_nxt   = sum_r + in_byte;
          state_nxt = F_LEN;
        end
        F_LEN: begin
          if (in_byte > MAX_B) begin
            q_push    = 1'b1;
            q_cmd     = '{is_frame: 1'b0, status: STAT_BAD_LEN, id: id_r, len: '0};
            state_nxt = F_WAIT;
          end else begin
            len_nxt = in_byte[LEN_W-1:0];
            sum_nxt = sum_r + in_byte;
            if (in_byte != 8'd0) begin
              state_nxt = F_DATA;
            end else if (cks_en_r) begin
              state_nxt = F_CSUM;
            end else begin
              q_push    = 1'b1;
              q_cmd     = '{is_frame: 1'b1, status: STAT_OK, id: id_r, len: '0};
              state_nxt = F_WAIT;
            end
          end
        end
        F_DATA: begin
          ram_wr_en = 1'b1;
          cnt_nxt   = cnt_inc;
          sum_nxt   = sum_r + in_byte;
          if (cnt_inc >= len_r) begin
            if (cks_en_r) begin
              state_nxt = F_CSUM;
            end else begin
              q_push    = 1'b1;
              q_cmd     = '{is_frame: 1'b1, status: STAT_OK, id: id_r, len: len_r};
              state_nxt = F_WAIT;
            end
          end
        end
        F_CSUM: begin
          q_push = 1'b1;
          if (in_byte == sum_r) begin
            q_cmd = '{is_frame: 1'b1, status: STAT_OK, id: id_r, len: len_r};
          end else begin
            q_cmd = '{is_frame: 1'b0, status: STAT_BAD_SUM, id: id_r, len: len_r};
          end
          state_nxt = F_WAIT;
        end
        default: begin
          id_nxt  = '0;
          len_nxt = '0;
          cnt_nxt = '0;
          sum_nxt = '0;
          if (in_byte == HEADER_BYTE) begin
            state_nxt = F_IDH;
          end else begin
            q_push    = 1'b1;
            q_cmd     = '{is_frame: 1'b0, status: STAT_BAD_HDR, id: '0, len: '0};
            state_nxt = F_WAIT;
          end
        end
      endcase
    end
    // The buffer stays owned by the output side until its last byte is read.
    busy_nxt = (busy_r && !buf_done) ||
               (q_push && q_cmd.is_frame && (q_cmd.len != '0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_WAIT;
      cks_en_r <= 1'b1;
      busy_r   <= 1'b0;
      id_r     <= '0;
      len_r    <= '0;
      cnt_r    <= '0;
      sum_r    <= '0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      if (cfg_wr_en) begin
        cks_en_r <= cfg_wr_data;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/sfd_back.sv @@
// ----------------------------------------------------------------------------
// sfd_back
// Output sequencer: turns queued commands into result beats, reading the
// payload buffer one byte per beat for good frames.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_back
  import sfd_pkg::*;
#(
  parameter int MAX_DATA = MAX_DATA_DEF,
  parameter int AW       = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  input  wire cmd_t          q_head,
  output logic               q_pop,
  output logic               buf_done,
  output logic               ram_rd_en,
  output logic [AW-1:0]      ram_rd_addr,
  input  wire logic [7:0]    ram_rd_data,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [39:0]        out_tdata,
  output logic               out_tlast
);

  back_state_t      state_r, state_nxt;
  logic [15:0]      id_r, id_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic [LEN_W-1:0] idx_inc;
  logic             slot_free;

  logic             ov_r, ov_nxt;
  logic             load;
  status_t          o_status;
  logic [15:0]      o_id;
  logic [3:0]       o_len;
  logic [2:0]       o_idx;
  logic [7:0]       o_byte;
  logic             o_last;
  logic [39:0]      data_r;
  logic             last_r;

  assign slot_free   = !ov_r || out_tready;
  assign idx_inc     = idx_r + LEN_W'(1);
  assign ram_rd_addr = idx_r[AW-1:0];
  assign out_tvalid  = ov_r;
  assign out_tdata   = data_r;
  assign out_tlast   = last_r;

  always_comb begin
    state_nxt = state_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    q_pop     = 1'b0;
    buf_done  = 1'b0;
    ram_rd_en = 1'b0;
    load      = 1'b0;
    o_status  = q_head.status;
    o_id      = q_head.id;
    o_len     = 4'(q_head.len);
    o_idx     = '0;
    o_byte    = '0;
    o_last    = 1'b1;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty && slot_free) begin
          q_pop = 1'b1;
          if (q_head.is_frame && (q_head.len != '0)) begin
            id_nxt    = q_head.id;
            len_nxt   = q_head.len;
            idx_nxt   = '0;
            state_nxt = B_READ;
          end else begin
            // Status beat or an empty frame: one beat straight from the command.
            load = 1'b1;
          end
        end
      end
      B_READ: begin
        ram_rd_en = 1'b1;
        state_nxt = B_EMIT;
      end
      B_EMIT: begin
        o_status = STAT_OK;
        o_id     = id_r;
        o_len    = 4'(len_r);
        o_idx    = 3'(idx_r);
        o_byte   = ram_rd_data;
        o_last   = (idx_inc == len_r);
        if (slot_free) begin
          load = 1'b1;
          if (o_last) begin
            buf_done  = 1'b1;
            state_nxt = B_IDLE;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = B_READ;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
    ov_nxt = load || (ov_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    len_r <= len_nxt;
    idx_r <= idx_nxt;
    if (load) begin
      data_r <= {7'b0, o_byte, o_idx, o_len, o_id, o_status};
      last_r <= o_last;
    end
  end

endmodule

`default_nettype wire

@@ design/serial_frame_deframer_core.sv @@
// ----------------------------------------------------------------------------
// serial_frame_deframer_core
// Rebuilds 'T'-headed frames from a byte stream, checks the additive
// checksum when enabled and emits one beat per data byte or one status beat.
// ----------------------------------------------------------------------------
// Input: one byte per cycle while the command queue is not full; data bytes
//   of a new frame wait until the prior frame's payload is read out.
// Output: after a result's closing byte is accepted, its command is queued and
//   its first beat loaded into the output register (a frame with payload reads
//   the buffer first); payload beats are paced by the buffer read and output register.
// Reset (rst_n low, synchronous): parser waits for a header, queue and
//   output are emptied, checksum_enabled returns to 1.
`default_nettype none

module serial_frame_deframer_core
  import sfd_pkg::*;
#(
  parameter int MAX_DATA = MAX_DATA_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,   // checksum_enabled
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,      // [7:0] byte_value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [1:0] status, [17:2] frame_id, [21:18] frame_length, [24:22] data_index,
  // [32:25] data_byte, [39:33] zero
  output logic [39:0]      out_tdata,
  output logic             out_tlast      // last
);

  localparam int AW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;

  logic          q_push, q_pop, q_full, q_empty;
  cmd_t          q_cmd, q_head;
  logic          buf_done;
  logic          ram_wr_en, ram_rd_en;
  logic [AW-1:0] ram_wr_addr, ram_rd_addr;
  logic [7:0]    ram_wr_data, ram_rd_data;

  sfd_front #(.MAX_DATA(MAX_DATA), .AW(AW)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_byte     (in_tdata),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_cmd),
    .buf_done    (buf_done),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data)
  );

  sfd_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head_cmd (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  sfd_ram #(.WIDTH(8), .DEPTH(MAX_DATA), .AW(AW)) u_payload (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  sfd_back #(.MAX_DATA(MAX_DATA), .AW(AW)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .buf_done    (buf_done),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

`default_nettype wire
